>>> src/wavp_pkg.sv
// shared types, constants and the int16 to float32 conversion for the wav parser
package wavp_pkg;

  typedef enum logic [2:0] {
    PH_HEADER     = 3'd0,
    PH_SKIP       = 3'd1,
    PH_TAG        = 3'd2,
    PH_SIZE_DATA  = 3'd3,
    PH_SIZE_OTHER = 3'd4,
    PH_DATA       = 3'd5,
    PH_TAIL       = 3'd6,
    PH_HALT       = 3'd7
  } phase_t;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_TOO_SMALL = 4'd1,
    ST_NO_RIFF   = 4'd2,
    ST_NO_WAVE   = 4'd3,
    ST_NO_FMT    = 4'd4,
    ST_NOT_MONO  = 4'd5,
    ST_UNSUPP    = 4'd6,
    ST_NO_DATA   = 4'd7,
    ST_TRUNC     = 4'd8
  } status_t;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [33:0] REPORT_POS = 34'd43;
  localparam logic [33:0] POS_MAX    = '1;
  localparam int          QDEPTH     = 2;

  // one classified result item, from the parser to the output stage
  typedef struct packed {
    logic        sample_valid;
    logic        sample_is_int;
    logic [31:0] sample_raw;
    logic        done_res;
    status_t     status;
    logic [31:0] rate_out;
  } res_t;

  // exact int16 * 2^-15 as float32 bits
  function automatic logic [31:0] int16_to_f32(input logic [15:0] raw);
    logic        sgn;
    logic [15:0] mag;
    logic [4:0]  msb;
    logic [22:0] man;
    logic [7:0]  ex;
    logic [31:0] sh;
    sgn = raw[15];
    mag = sgn ? (~raw + 16'd1) : raw;
    msb = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (mag[i]) msb = 5'(i);
    end
    sh  = {16'd0, mag} << (5'd23 - msb);
    man = sh[22:0];
    ex  = 8'(8'd112 + {3'd0, msb});
    if (mag == 16'd0) int16_to_f32 = 32'd0;
    else int16_to_f32 = {sgn, ex, man};
  endfunction

endpackage

>>> src/wavp_front.sv
// byte parser: header checks, chunk walk, sample assembly
module wavp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  logic [7:0]      in_byte,
  input  logic            in_eof,
  output logic            res_vld,
  output wavp_pkg::res_t  res
);

  logic [33:0]       pos_r, pos_nxt;
  wavp_pkg::phase_t  ph_r, ph_nxt;
  logic [31:0]       hs_r, hs_nxt;
  logic [31:0]       fmtlen_r, fmtlen_nxt;
  logic [15:0]       fcode_r, fcode_nxt;
  logic [15:0]       chan_r, chan_nxt;
  logic [31:0]       rate_r, rate_nxt;
  wavp_pkg::status_t err_r, err_nxt;
  logic [32:0]       left_r, left_nxt;
  logic [31:0]       dleft_r, dleft_nxt;
  logic [31:0]       asm_r, asm_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic [31:0]       shift;
  logic [15:0]       swb;
  logic [32:0]       left_dec;
  logic              have_s;
  logic              rep;
  wavp_pkg::status_t st;

  assign shift    = {in_byte, hs_r[31:8]};
  assign swb      = shift[31:16];
  assign left_dec = left_r - 33'd1;

  // next state for one accepted item
  always_comb begin
    pos_nxt = pos_r; ph_nxt = ph_r; hs_nxt = hs_r; fmtlen_nxt = fmtlen_r;
    fcode_nxt = fcode_r; chan_nxt = chan_r; rate_nxt = rate_r; err_nxt = err_r;
    left_nxt = left_r; dleft_nxt = dleft_r; asm_nxt = asm_r; cnt_nxt = cnt_r;
    have_s = 1'b0;
    case (ph_r)
      wavp_pkg::PH_HEADER: begin
        hs_nxt = shift;
        if (pos_r == 34'd3 && shift != wavp_pkg::TAG_RIFF && err_nxt == wavp_pkg::ST_OK)
          err_nxt = wavp_pkg::ST_NO_RIFF;
        if (pos_r == 34'd11 && shift != wavp_pkg::TAG_WAVE && err_nxt == wavp_pkg::ST_OK)
          err_nxt = wavp_pkg::ST_NO_WAVE;
        if (pos_r == 34'd15 && shift != wavp_pkg::TAG_FMT && err_nxt == wavp_pkg::ST_OK)
          err_nxt = wavp_pkg::ST_NO_FMT;
        if (pos_r == 34'd19) fmtlen_nxt = shift;
        if (pos_r == 34'd21) fcode_nxt = shift[31:16];
        if (pos_r == 34'd23) chan_nxt = shift[31:16];
        if (pos_r == 34'd27) rate_nxt = shift;
        if (pos_r == 34'd35) begin
          if (err_nxt == wavp_pkg::ST_OK) begin
            if (chan_r != 16'd1) err_nxt = wavp_pkg::ST_NOT_MONO;
            else if (fmtlen_r < 32'd16 ||
                     !((fcode_r == 16'd1 && swb == 16'd16) ||
                       (fcode_r == 16'd3 && swb == 16'd32)))
              err_nxt = wavp_pkg::ST_UNSUPP;
          end
          if (err_nxt == wavp_pkg::ST_OK) begin
            if (fmtlen_r == 32'd16) begin
              ph_nxt = wavp_pkg::PH_TAG; left_nxt = 33'd4;
            end else begin
              ph_nxt = wavp_pkg::PH_SKIP; left_nxt = {1'b0, fmtlen_r - 32'd16};
            end
          end
        end
        if (err_nxt != wavp_pkg::ST_OK) ph_nxt = wavp_pkg::PH_HALT;
      end
      wavp_pkg::PH_SKIP: begin
        left_nxt = left_dec;
        if (left_dec == 33'd0) begin
          ph_nxt = wavp_pkg::PH_TAG; left_nxt = 33'd4;
        end
      end
      wavp_pkg::PH_TAG: begin
        hs_nxt = shift; left_nxt = left_dec;
        if (left_dec == 33'd0) begin
          ph_nxt = (shift == wavp_pkg::TAG_DATA) ? wavp_pkg::PH_SIZE_DATA
                                                 : wavp_pkg::PH_SIZE_OTHER;
          left_nxt = 33'd4;
        end
      end
      wavp_pkg::PH_SIZE_DATA, wavp_pkg::PH_SIZE_OTHER: begin
        hs_nxt = shift; left_nxt = left_dec;
        if (left_dec == 33'd0) begin
          if (ph_r == wavp_pkg::PH_SIZE_DATA) begin
            dleft_nxt = shift; cnt_nxt = 2'd0;
            ph_nxt = (shift == 32'd0) ? wavp_pkg::PH_TAIL : wavp_pkg::PH_DATA;
          end else begin
            left_nxt = {1'b0, shift} + {32'd0, shift[0]};
            if (shift == 32'd0) begin
              ph_nxt = wavp_pkg::PH_TAG; left_nxt = 33'd4;
            end else begin
              ph_nxt = wavp_pkg::PH_SKIP;
            end
          end
        end
      end
      wavp_pkg::PH_DATA: begin
        asm_nxt   = {in_byte, asm_r[31:8]};
        dleft_nxt = dleft_r - 32'd1;
        if (cnt_r == ((fcode_r == 16'd1) ? 2'd1 : 2'd3)) begin
          cnt_nxt = 2'd0; have_s = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
        if (dleft_nxt == 32'd0) ph_nxt = wavp_pkg::PH_TAIL;
      end
      default: ;
    endcase
    if (pos_r != wavp_pkg::POS_MAX) pos_nxt = pos_r + 34'd1;
  end

  // done status for this item
  always_comb begin
    rep = 1'b0;
    st  = wavp_pkg::ST_OK;
    if (in_eof) begin
      rep = 1'b1;
      if (pos_r < wavp_pkg::REPORT_POS) st = wavp_pkg::ST_TOO_SMALL;
      else if (err_nxt != wavp_pkg::ST_OK) begin
        st = err_nxt; rep = (pos_r == wavp_pkg::REPORT_POS);
      end else if (ph_nxt == wavp_pkg::PH_TAIL) st = wavp_pkg::ST_OK;
      else if (ph_nxt == wavp_pkg::PH_DATA) st = wavp_pkg::ST_TRUNC;
      else st = wavp_pkg::ST_NO_DATA;
    end else if (err_nxt != wavp_pkg::ST_OK && pos_r == wavp_pkg::REPORT_POS) begin
      rep = 1'b1; st = err_nxt;
    end
  end

  // result item toward the queue
  always_comb begin
    res_vld           = in_vld && (rep || have_s);
    res.sample_valid  = have_s;
    res.sample_is_int = (fcode_r == 16'd1);
    res.sample_raw    = have_s ? asm_nxt : 32'd0;
    res.done_res      = rep;
    res.status        = rep ? st : wavp_pkg::ST_OK;
    res.rate_out      = (rep && st == wavp_pkg::ST_OK) ? rate_r : 32'd0;
  end

  // state registers, cleared again after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n || (in_vld && in_eof)) begin
      pos_r <= '0; ph_r <= wavp_pkg::PH_HEADER; hs_r <= '0; fmtlen_r <= '0;
      fcode_r <= '0; chan_r <= '0; rate_r <= '0; err_r <= wavp_pkg::ST_OK;
      left_r <= '0; dleft_r <= '0; asm_r <= '0; cnt_r <= '0;
    end else if (in_vld) begin
      pos_r <= pos_nxt; ph_r <= ph_nxt; hs_r <= hs_nxt; fmtlen_r <= fmtlen_nxt;
      fcode_r <= fcode_nxt; chan_r <= chan_nxt; rate_r <= rate_nxt; err_r <= err_nxt;
      left_r <= left_nxt; dleft_r <= dleft_nxt; asm_r <= asm_nxt; cnt_r <= cnt_nxt;
    end
  end

  // an error once latched stays until the end of the file
  assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != wavp_pkg::ST_OK && !(in_vld && in_eof)) |=> err_r == $past(err_r))
    else $error("latched error changed");
  // a latched error always parks the parser
  assert property (@(posedge clk) disable iff (!rst_n)
    err_r != wavp_pkg::ST_OK |-> ph_r == wavp_pkg::PH_HALT)
    else $error("error without halt");
  // the data phase only runs with bytes left
  assert property (@(posedge clk) disable iff (!rst_n)
    ph_r == wavp_pkg::PH_DATA |-> dleft_r != 32'd0)
    else $error("data phase with nothing left");

endmodule

>>> src/wavp_back.sv
// result queue and output stage: float conversion and stream handshake
module wavp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            res_vld,
  input  wavp_pkg::res_t  res,
  output logic            q_ready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [71:0]     out_tdata
);

  wavp_pkg::res_t q_r [wavp_pkg::QDEPTH];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push, pop;
  wavp_pkg::res_t h;
  logic [31:0]    sbits;

  assign q_ready    = (cnt_r != 2'd2);
  assign push       = res_vld && q_ready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign pop        = out_tvalid && out_tready;
  assign cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= res;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end

  // convert the head item
  always_comb begin
    h = q_r[rp_r];
    if (!h.sample_valid) sbits = 32'd0;
    else if (h.sample_is_int) sbits = wavp_pkg::int16_to_f32(h.sample_raw[31:16]);
    else sbits = h.sample_raw;
    out_tdata = {2'b00, h.rate_out, h.status, h.done_res, sbits, h.sample_valid};
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop) |=> cnt_r == 2'd2)
    else $error("full queue lost an item");
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !pop)
    else $error("pop from empty queue");

endmodule

>>> src/wav_mono_stream_parser.sv
// top level: streaming mono wav parser
//  channel | dir | tdata fields (low bit first)                          | tlast
//  in_     | in  | file_byte[7:0]                                        | end_of_file
//  out_    | out | sample_valid, sample_bits[31:0], done_res, status[3:0],
//          |     | rate_out[31:0], two zero fill bits                    | -
// one byte is taken every cycle while in_tready is high; a result leaves in the cycle after its byte at the earliest
// the parser updates on the accept edge and pushes its result into a two-entry queue
// the queue head drives the out_ channel through the float conversion
// in_tready drops while the queue holds two items, until the output side takes one
// reset is synchronous active low; after the final byte the parser restarts for a new file
module wav_mono_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // file_byte
  input  logic        in_tlast,   // end_of_file
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // sample_valid, sample_bits, done_res, status, rate_out
);

  logic           res_vld;
  wavp_pkg::res_t res;
  logic           q_ready;

  assign in_tready = q_ready;

  wavp_front u_front (
    .clk(clk), .rst_n(rst_n), .in_vld(in_tvalid && in_tready),
    .in_byte(in_tdata), .in_eof(in_tlast), .res_vld(res_vld), .res(res)
  );

  wavp_back u_back (
    .clk(clk), .rst_n(rst_n), .res_vld(res_vld), .res(res), .q_ready(q_ready),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

endmodule

>>> test/wav_mono_stream_checker.sv
// checker for the wav parser: predicts every result item and compares it on the out_ channel
module wav_mono_stream_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // file_byte
  input  logic        in_tlast,   // end_of_file
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,  // sample_valid, sample_bits, done_res, status, rate_out
  output int          fail_count,
  output int          pending
);

  // predicted parser state
  logic [33:0]      pos_r;
  wavp_pkg::phase_t phase_r;
  logic [31:0]      hdr_r;
  logic [31:0]      fmt_len_r;
  logic [15:0]      fmt_code_r;
  logic [15:0]      chans_r;
  logic [31:0]      rate_r;
  logic [15:0]      width_r;
  logic [3:0]       err_r;
  logic [32:0]      chunk_r;
  logic [31:0]      data_left_r;
  logic [31:0]      asm_r;
  logic [1:0]       nbytes_r;

  logic [71:0] expected_items[$];

  function automatic void clear_parser();
    pos_r = '0; phase_r = wavp_pkg::PH_HEADER; hdr_r = '0; fmt_len_r = '0; fmt_code_r = '0;
    chans_r = '0; rate_r = '0; width_r = '0; err_r = '0; chunk_r = '0;
    data_left_r = '0; asm_r = '0; nbytes_r = '0;
  endfunction

  function automatic void latch_error(input logic [3:0] code);
    if (err_r == 4'd0) err_r = code;
  endfunction

  // int16 scaled by 2^-15, normalized by shifting left until the top bit is set
  function automatic logic [31:0] pcm16_bits(input logic [15:0] r);
    logic [15:0] m;
    logic [7:0]  e;
    m = r[15] ? (~r + 16'd1) : r;
    e = 8'd127;
    if (r == 16'd0) return 32'd0;
    for (int i = 0; i < 16; i++) begin
      if (!m[15]) begin
        m = m << 1;
        e = e - 8'd1;
      end
    end
    return {r[15], e, m[14:0], 8'd0};
  endfunction

  function automatic logic [71:0] pack_item(input logic sv, input logic [31:0] sb,
                                            input logic dn, input logic [3:0] st,
                                            input logic [31:0] rt);
    return {2'b00, rt, st, dn, sb, sv};
  endfunction

  // one file byte through the predicted parser
  function automatic void parse_byte(input logic [7:0] b, input logic eof);
    logic [33:0] p;
    logic [31:0] sh;
    logic        got;
    logic [31:0] sbits;
    logic [3:0]  st;
    logic        rep;
    logic [1:0]  last_idx;
    p = pos_r;
    sh = {b, hdr_r[31:8]};
    got = 1'b0;
    sbits = '0;
    case (phase_r)
      wavp_pkg::PH_HEADER: begin
        hdr_r = sh;
        if (p == 34'd3 && sh != wavp_pkg::TAG_RIFF) latch_error(wavp_pkg::ST_NO_RIFF);
        if (p == 34'd11 && sh != wavp_pkg::TAG_WAVE) latch_error(wavp_pkg::ST_NO_WAVE);
        if (p == 34'd15 && sh != wavp_pkg::TAG_FMT) latch_error(wavp_pkg::ST_NO_FMT);
        if (p == 34'd19) fmt_len_r = sh;
        if (p == 34'd21) fmt_code_r = sh[31:16];
        if (p == 34'd23) chans_r = sh[31:16];
        if (p == 34'd27) rate_r = sh;
        if (p == 34'd35) begin
          width_r = sh[31:16];
          if (chans_r != 16'd1) latch_error(wavp_pkg::ST_NOT_MONO);
          else if (fmt_len_r < 32'd16 ||
                   !((fmt_code_r == 16'd1 && width_r == 16'd16) ||
                     (fmt_code_r == 16'd3 && width_r == 16'd32)))
            latch_error(wavp_pkg::ST_UNSUPP);
          if (err_r == 4'd0) begin
            chunk_r = {1'b0, fmt_len_r} - 33'd16;
            if (chunk_r == 33'd0) begin
              phase_r = wavp_pkg::PH_TAG;
              chunk_r = 33'd4;
            end else phase_r = wavp_pkg::PH_SKIP;
          end
        end
        if (err_r != 4'd0) phase_r = wavp_pkg::PH_HALT;
      end
      wavp_pkg::PH_SKIP: begin
        chunk_r = chunk_r - 33'd1;
        if (chunk_r == 33'd0) begin
          phase_r = wavp_pkg::PH_TAG;
          chunk_r = 33'd4;
        end
      end
      wavp_pkg::PH_TAG: begin
        hdr_r = sh;
        chunk_r = chunk_r - 33'd1;
        if (chunk_r == 33'd0) begin
          phase_r = (sh == wavp_pkg::TAG_DATA) ? wavp_pkg::PH_SIZE_DATA
                                               : wavp_pkg::PH_SIZE_OTHER;
          chunk_r = 33'd4;
        end
      end
      wavp_pkg::PH_SIZE_DATA, wavp_pkg::PH_SIZE_OTHER: begin
        hdr_r = sh;
        chunk_r = chunk_r - 33'd1;
        if (chunk_r == 33'd0) begin
          if (phase_r == wavp_pkg::PH_SIZE_DATA) begin
            data_left_r = sh;
            nbytes_r = '0;
            phase_r = (sh == 32'd0) ? wavp_pkg::PH_TAIL : wavp_pkg::PH_DATA;
          end else begin
            chunk_r = {1'b0, sh} + {32'd0, sh[0]};
            if (chunk_r == 33'd0) begin
              phase_r = wavp_pkg::PH_TAG;
              chunk_r = 33'd4;
            end else phase_r = wavp_pkg::PH_SKIP;
          end
        end
      end
      wavp_pkg::PH_DATA: begin
        last_idx = (fmt_code_r == 16'd1) ? 2'd1 : 2'd3;
        asm_r = {b, asm_r[31:8]};
        data_left_r = data_left_r - 32'd1;
        if (nbytes_r == last_idx) begin
          nbytes_r = '0;
          got = 1'b1;
          sbits = (last_idx == 2'd1) ? pcm16_bits(asm_r[31:16]) : asm_r;
        end else nbytes_r = nbytes_r + 2'd1;
        if (data_left_r == 32'd0) phase_r = wavp_pkg::PH_TAIL;
      end
      default: ;
    endcase
    if (pos_r != wavp_pkg::POS_MAX) pos_r = pos_r + 34'd1;

    if (eof) begin
      rep = 1'b1;
      if (p < wavp_pkg::REPORT_POS) st = wavp_pkg::ST_TOO_SMALL;
      else if (err_r != 4'd0) begin
        st = err_r;
        rep = (p == wavp_pkg::REPORT_POS);
      end else if (phase_r == wavp_pkg::PH_TAIL) st = wavp_pkg::ST_OK;
      else if (phase_r == wavp_pkg::PH_DATA) st = wavp_pkg::ST_TRUNC;
      else st = wavp_pkg::ST_NO_DATA;
      if (rep || got)
        expected_items.push_back(pack_item(got, sbits, rep, rep ? st : 4'd0,
                                           (rep && st == wavp_pkg::ST_OK) ? rate_r : 32'd0));
      clear_parser();
    end else if (err_r != 4'd0 && p == wavp_pkg::REPORT_POS) begin
      expected_items.push_back(pack_item(got, sbits, 1'b1, err_r, 32'd0));
    end else if (got) begin
      expected_items.push_back(pack_item(1'b1, sbits, 1'b0, 4'd0, 32'd0));
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [71:0] got_item,
                                 input logic [71:0] exp_item);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got_item, exp_item);
    fail_count++;
  endtask

  // watch both channels on every edge
  always @(posedge clk) begin
    logic [71:0] e;
    if (!rst_n) begin
      clear_parser();
      expected_items.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_items.size() == 0) report_mismatch("unexpected item", out_tdata, '0);
        else begin
          e = expected_items.pop_front();
          if (out_tdata[0] !== e[0]) report_mismatch("sample_valid", out_tdata, e);
          if (out_tdata[32:1] !== e[32:1]) report_mismatch("sample_bits", out_tdata, e);
          if (out_tdata[33] !== e[33]) report_mismatch("done_res", out_tdata, e);
          if (out_tdata[37:34] !== e[37:34]) report_mismatch("status", out_tdata, e);
          if (out_tdata[69:38] !== e[69:38]) report_mismatch("rate_out", out_tdata, e);
          if (out_tdata[71:70] !== e[71:70]) report_mismatch("fill bits", out_tdata, e);
        end
      end
      if (in_tvalid && in_tready) parse_byte(in_tdata, in_tlast);
    end
    pending = expected_items.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end

endmodule

>>> test/wav_mono_stream_parser_tb.sv
// testbench top for the wav parser: builds wav files as byte streams and gives the verdict
module wav_mono_stream_parser_tb;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // file_byte
  logic        in_tlast;   // end_of_file
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // sample_valid, sample_bits, done_res, status, rate_out
  int          fail_count;
  int          pending;
  int          bytes_sent;
  bit          no_gaps;
  bit          sink_steady;
  logic [7:0]  wav_bytes[$];

  wav_mono_stream_parser uut (.*);

  wav_mono_stream_checker chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("wav_mono_stream_parser_tb failed");
    $finish;
  end

  function automatic void put16(input logic [15:0] v);
    wav_bytes.push_back(v[7:0]);
    wav_bytes.push_back(v[15:8]);
  endfunction

  function automatic void put32(input logic [31:0] v);
    put16(v[15:0]);
    put16(v[31:16]);
  endfunction

  function automatic void put_rand(input int n);
    for (int i = 0; i < n; i++) wav_bytes.push_back(8'($urandom));
  endfunction

  // header, optional fmt extension, skipped chunks, then data
  function automatic void build_wav(input logic [15:0] code, input logic [15:0] chans,
                                    input logic [15:0] bits, input logic [31:0] fmt_len,
                                    input int extra_chunks, input logic [31:0] data_len,
                                    input int data_bytes);
    logic [31:0] sz;
    wav_bytes.delete();
    put32(wavp_pkg::TAG_RIFF);
    put32($urandom);
    put32(wavp_pkg::TAG_WAVE);
    put32(wavp_pkg::TAG_FMT);
    put32(fmt_len);
    put16(code);
    put16(chans);
    put32($urandom);
    put32($urandom);
    put16(16'($urandom));
    put16(bits);
    if (fmt_len > 32'd16 && fmt_len < 32'd64) put_rand(fmt_len - 16);
    for (int c = 0; c < extra_chunks; c++) begin
      sz = $urandom_range(0, 5);
      put32({8'($urandom_range(0, 96)), 24'($urandom)});
      put32(sz);
      put_rand(sz + sz[0]);
    end
    put32(wavp_pkg::TAG_DATA);
    put32(data_len);
    put_rand(data_bytes);
  endfunction

  // one byte per item, random gap before it unless this file runs gap-free
  task automatic send_file();
    int gap;
    for (int i = 0; i < wav_bytes.size(); i++) begin
      gap = no_gaps ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= wav_bytes[i];
      in_tlast  <= (i == wav_bytes.size() - 1);
      do @(posedge clk); while (!in_tready);
      bytes_sent++;
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
  endtask

  // let the checker predict the last accepted item first, then wait until none is pending
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // random legal-looking file with occasional corruption, early end, trailing bytes or pure random bytes
  task automatic random_file();
    logic [15:0] code;
    int          dn;
    int          n;
    int          pick;
    code = $urandom_range(0, 1) ? 16'd1 : 16'd3;
    dn = $urandom_range(0, 40);
    build_wav(code, 16'd1, code == 16'd1 ? 16'd16 : 16'd32,
              $urandom_range(0, 3) == 0 ? 32'($urandom_range(16, 21)) : 32'd16,
              $urandom_range(0, 2),
              $urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 50)) : 32'(dn), dn);
    pick = $urandom_range(0, 9);
    if (pick == 0) wav_bytes[$urandom_range(0, 35)] = 8'($urandom);
    else if (pick == 1) begin
      n = $urandom_range(1, wav_bytes.size());
      while (wav_bytes.size() > n) void'(wav_bytes.pop_back());
    end else if (pick == 2) put_rand($urandom_range(1, 8));
    else if (pick == 3) begin
      wav_bytes.delete();
      put_rand($urandom_range(1, 60));
    end
    no_gaps = ($urandom_range(0, 3) == 0);
    send_file();
  endtask

  // result side: random stall before each item, sometimes long steady stretches
  initial begin
    int w;
    out_tready = 1'b0;
    sink_steady = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 29) == 0) sink_steady = ~sink_steady;
      w = sink_steady ? 0 : $urandom_range(0, 17);
      if (w > 0) begin
        out_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    bytes_sent = 0;
    no_gaps = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // pcm16 with extreme samples, held until everything has drained
    build_wav(16'd1, 16'd1, 16'd16, 32'd16, 0, 32'd10, 0);
    put16(16'h8000); put16(16'h7fff); put16(16'h0000); put16(16'h0001); put16(16'hffff);
    send_file();
    drain();
    // float32 with one extra chunk of random size and fmt extension, data ends on a whole sample
    build_wav(16'd3, 16'd1, 16'd32, 32'd18, 1, 32'd8, 0);
    put32(32'hffff_ffff); put32(32'h0000_0000);
    send_file();
    // error cases: tags, mono, format, short fmt
    build_wav(16'd1, 16'd2, 16'd16, 32'd16, 0, 32'd2, 2); send_file();
    build_wav(16'd1, 16'd1, 16'd8, 32'd16, 0, 32'd2, 2); send_file();
    build_wav(16'd1, 16'd1, 16'd16, 32'd14, 0, 32'd2, 2); send_file();
    build_wav(16'd1, 16'd1, 16'd16, 32'd16, 0, 32'd2, 2); wav_bytes[0] = 8'h00; send_file();
    build_wav(16'd1, 16'd1, 16'd16, 32'd16, 0, 32'd2, 2); wav_bytes[9] = 8'h00; send_file();
    build_wav(16'd1, 16'd1, 16'd16, 32'd16, 0, 32'd2, 2); wav_bytes[14] = 8'h00; send_file();
    // error file ending exactly at the report byte, and a too-small file
    build_wav(16'd1, 16'd2, 16'd16, 32'd16, 0, 32'd0, 0); send_file();
    build_wav(16'd1, 16'd1, 16'd16, 32'd16, 0, 32'd0, 0); void'(wav_bytes.pop_back());
    send_file();
    // truncated data, zero-length data, missing data chunk
    build_wav(16'd1, 16'd1, 16'd16, 32'd20, 0, 32'd4, 3); send_file();
    build_wav(16'd3, 16'd1, 16'd32, 32'd16, 0, 32'd0, 0); send_file();
    build_wav(16'd1, 16'd1, 16'd16, 32'd16, 0, 32'd0, 0);
    repeat (8) void'(wav_bytes.pop_back());
    put32(32'h1234_5678); put32(32'd3); put_rand(2);
    send_file();

    while (bytes_sent < 1150) random_file();

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("wav_mono_stream_parser_tb passed");
    else $display("wav_mono_stream_parser_tb failed");
    $finish;
  end

endmodule

>>> sim.f
src/wavp_pkg.sv
src/wavp_front.sv
src/wavp_back.sv
src/wav_mono_stream_parser.sv
test/wav_mono_stream_checker.sv
test/wav_mono_stream_parser_tb.sv
